// ===== hdl/tnnt_pkg.sv =====
// ----------------------------------------------------------------------------
// tnnt_pkg
// Shared types for the two-nearest-neighbour triangle block.
// ----------------------------------------------------------------------------
package tnnt_pkg;

  localparam int unsigned IdxBits = 6;

  // one command from the loader to the search engine
  typedef struct packed {
    logic       too_few;
    logic [10:0] count;
  } run_cmd_t;

endpackage

// ===== hdl/tnnt_front.sv =====
// ----------------------------------------------------------------------------
// tnnt_front
// Accepts points, writes the coordinate stores and issues search runs.
// ----------------------------------------------------------------------------
module tnnt_front import tnnt_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [COORD_BITS-1:0] pz_i,
  input  logic                  last_point_i,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [3*COORD_BITS-1:0] wr_data_o,
  output logic                  cmd_valid_o,
  output run_cmd_t              cmd_o,
  input  logic                  cmd_ready_i,
  input  logic                  busy_i
);

  logic [AW:0] cnt_q, cnt_d;
  logic        cmd_valid_q, cmd_valid_d;
  run_cmd_t    cmd_q, cmd_d;
  logic        acc, store;
  logic [AW:0] n;
  logic [COORD_BITS-1:0] sgn;

  assign sgn = {1'b1, {(COORD_BITS-1){1'b0}}};
  assign full_o = cmd_valid_q || busy_i;
  assign acc = push_i && !full_o;
  assign store = acc && (cnt_q < (AW+1)'(MAX_POINTS));
  assign wr_en_o = store;
  assign wr_addr_o = cnt_q[AW-1:0];
  assign wr_data_o = {px_i ^ sgn, py_i ^ sgn, pz_i ^ sgn};
  assign n = store ? cnt_q + 1'b1 : cnt_q;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o = cmd_q;

  always_comb begin
    cnt_d = cnt_q;
    cmd_valid_d = cmd_valid_q;
    cmd_d = cmd_q;
    if (cmd_valid_q && cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
    if (acc) begin
      cnt_d = n;
      if (last_point_i) begin
        cnt_d = '0;
        cmd_valid_d = 1'b1;
        cmd_d.too_few = n < 3;
        cmd_d.count = 11'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== hdl/tnnt_back.sv =====
// ----------------------------------------------------------------------------
// tnnt_back
// Brute-force two-nearest search over the stored points, one pair a cycle while no unpopped face holds it.
// ----------------------------------------------------------------------------
module tnnt_back import tnnt_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [3*COORD_BITS-1:0] wr_data_i,
  input  logic                  cmd_valid_i,
  input  run_cmd_t              cmd_i,
  output logic                  cmd_ready_o,
  output logic                  busy_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [IdxBits-1:0]    center_index_o,
  output logic [IdxBits-1:0]    near_index_o,
  output logic [IdxBits-1:0]    second_index_o,
  output logic                  last_face_o,
  output logic                  too_few_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SQ = 2*CB;
  localparam int unsigned DW = SQ + 2;
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;

  logic [3*CB-1:0] mem [MAX_POINTS];
  logic [3*CB-1:0] ci_q, rj_q;
  logic [1:0]  st_q;
  logic [AW:0] n_q, i_q, j_q, jr_q, js_q, jt_q;
  logic        v1_q, v2_q, v3_q;
  logic [CB-1:0] dx_q, dy_q, dz_q;
  logic [SQ-1:0] sx_q, sy_q, sz_q;
  logic [DW-1:0] bd_q, sd_q, d;
  logic [AW:0] bi_q, si_q;
  logic        hb_q, hs_q, fin_q;
  logic        ov_q;
  logic [IdxBits-1:0] oc_q, on_q, os_q;
  logic        ol_q, of_q;
  logic        issue, ci_load;
  logic [AW:0] ci_addr;

  function automatic logic [CB-1:0] adiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    adiff = (a >= b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rj_q <= mem[j_q[AW-1:0]];
    if (ci_load) begin
      ci_q <= mem[ci_addr[AW-1:0]];
    end
  end

  assign cmd_ready_o = st_q == S_IDLE && !ov_q;
  assign busy_o = st_q != S_IDLE;
  assign issue = (st_q == S_RUN) && !fin_q && (j_q < n_q);
  assign d = DW'(sx_q) + DW'(sy_q) + DW'(sz_q);
  assign empty_o = !ov_q;
  assign center_index_o = oc_q;
  assign near_index_o = on_q;
  assign second_index_o = os_q;
  assign last_face_o = ol_q;
  assign too_few_o = of_q;
  // load the next center: point zero at the start of a run, else the following one
  assign ci_addr = (st_q == S_IDLE) ? '0 : i_q + 1'b1;
  assign ci_load = (st_q == S_IDLE && cmd_valid_i && !ov_q && !cmd_i.too_few)
                   || (st_q == S_OUT && !ov_q && (i_q + 1'b1 < n_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      fin_q <= 1'b0;
      n_q <= '0;
      i_q <= '0;
      j_q <= '0;
      hb_q <= 1'b0;
      hs_q <= 1'b0;
      bd_q <= '1;
      sd_q <= '1;
      bi_q <= '0;
      si_q <= '0;
      oc_q <= '0;
      on_q <= '0;
      os_q <= '0;
      ol_q <= 1'b0;
      of_q <= 1'b0;
    end else begin
      if (ov_q && pop_i) begin
        ov_q <= 1'b0;
      end
      v1_q <= issue && (j_q != i_q);
      v2_q <= v1_q;
      v3_q <= v2_q;
      unique case (st_q)
        S_IDLE: begin
          if (cmd_valid_i && !ov_q) begin
            if (cmd_i.too_few) begin
              ov_q <= 1'b1;
              oc_q <= '0; on_q <= '0; os_q <= '0; ol_q <= 1'b1; of_q <= 1'b1;
            end else begin
              st_q <= S_RUN;
              n_q <= cmd_i.count[AW:0];
              i_q <= '0;
              j_q <= '0;
              fin_q <= 1'b0;
              hb_q <= 1'b0;
              hs_q <= 1'b0;
            end
          end
        end
        S_RUN: begin
          if (issue) begin
            j_q <= j_q + 1'b1;
          end else if (!v1_q && !v2_q && !v3_q) begin
            st_q <= S_OUT;
          end
          if (j_q == n_q) begin
            fin_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            oc_q <= i_q[IdxBits-1:0];
            on_q <= bi_q[IdxBits-1:0];
            os_q <= si_q[IdxBits-1:0];
            ol_q <= (i_q + 1'b1 == n_q);
            of_q <= 1'b0;
            hb_q <= 1'b0;
            hs_q <= 1'b0;
            fin_q <= 1'b0;
            j_q <= '0;
            if (i_q + 1'b1 == n_q) begin
              st_q <= S_IDLE;
            end else begin
              i_q <= i_q + 1'b1;
              st_q <= S_RUN;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
      if (v3_q) begin
        if (!hb_q || d < bd_q) begin
          if (hb_q) begin
            sd_q <= bd_q; si_q <= bi_q; hs_q <= 1'b1;
          end
          bd_q <= d; bi_q <= jt_q; hb_q <= 1'b1;
        end else if (!hs_q || d < sd_q) begin
          sd_q <= d; si_q <= jt_q; hs_q <= 1'b1;
        end
      end
    end
  end

  // distance stages lag: v1 marks read data, v2 differences, v3 squares
  always_ff @(posedge clk_i) begin
    jr_q <= j_q;
    dx_q <= adiff(ci_q[3*CB-1:2*CB], rj_q[3*CB-1:2*CB]);
    dy_q <= adiff(ci_q[2*CB-1:CB], rj_q[2*CB-1:CB]);
    dz_q <= adiff(ci_q[CB-1:0], rj_q[CB-1:0]);
    js_q <= jr_q;
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    sz_q <= dz_q * dz_q;
    jt_q <= js_q;
  end

endmodule

// ===== hdl/two_nearest_neighbour_triangles.sv =====
// ----------------------------------------------------------------------------
// two_nearest_neighbour_triangles
// Loads 3D points and emits one nearest-two triangle per stored point, or one error face for a set of under three.
// ----------------------------------------------------------------------------
// channel  | handshake   | payload
// points   | push / full | px, py, pz, last_point
// faces    | empty / pop | center/near/second index, last_face, too_few
// A point is taken when push meets full low. A flagged point starts a search over
// the stored points, one pair a cycle through a four-stage compare pipe.
// Reset clears counters and the run state; stores are undefined until written.
// Output stall holds the search; full stays high from the flagged point until
// the last face of its run is loaded.
module two_nearest_neighbour_triangles import tnnt_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [COORD_BITS-1:0] pz_i,
  input  logic                  last_point_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [IdxBits-1:0]    center_index_o,
  output logic [IdxBits-1:0]    near_index_o,
  output logic [IdxBits-1:0]    second_index_o,
  output logic                  last_face_o,
  output logic                  too_few_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic                    wr_en, cmd_valid, cmd_ready, busy;
  logic [AW-1:0]           wr_addr;
  logic [3*COORD_BITS-1:0] wr_data;
  run_cmd_t                cmd;

  tnnt_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .px_i, .py_i, .pz_i,
    .last_point_i, .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready), .busy_i(busy)
  );

  tnnt_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready), .busy_o(busy),
    .empty_o(empty), .pop_i(pop), .center_index_o, .near_index_o,
    .second_index_o, .last_face_o, .too_few_o
  );

endmodule

// ===== hdl/tnnt_checker.sv =====
// ----------------------------------------------------------------------------
// tnnt_checker
// Port-level checks for the triangle block.
// ----------------------------------------------------------------------------
module tnnt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [5:0] center_index_o,
  input logic [5:0] near_index_o,
  input logic [5:0] second_index_o,
  input logic       too_few_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(center_index_o)) else $error("face dropped");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && too_few_o |-> center_index_o == 6'd0 && near_index_o == 6'd0)
    else $error("error face not zero");
  a_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !too_few_o |-> near_index_o != center_index_o
      && second_index_o != center_index_o) else $error("self neighbour");

endmodule

bind two_nearest_neighbour_triangles tnnt_checker u_chk (.*);

// ===== bench/two_nearest_neighbour_triangles_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_nearest_neighbour_triangles_tb
// Loads point sets of many sizes (too few, typical, full store and overflow),
// predicts each point's two nearest neighbours with ties to the lower index,
// and checks every face against the prediction in order, under random
// sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module two_nearest_neighbour_triangles_tb;
  import tnnt_pkg::*;

  localparam int unsigned MaxPoints = 64;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } point_t;

  typedef struct {
    logic [IdxBits-1:0] center;
    logic [IdxBits-1:0] near;
    logic [IdxBits-1:0] second;
    logic               last_face;
    logic               too_few;
  } face_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [15:0] px_i;
  logic signed [15:0] py_i;
  logic signed [15:0] pz_i;
  logic               last_point_i;
  logic               empty;
  logic               pop;
  logic [IdxBits-1:0] center_index_o;
  logic [IdxBits-1:0] near_index_o;
  logic [IdxBits-1:0] second_index_o;
  logic               last_face_o;
  logic               too_few_o;

  point_t             point_q[$];
  face_t              face_q[$];
  logic signed [15:0] xs[MaxPoints];
  logic signed [15:0] ys[MaxPoints];
  logic signed [15:0] zs[MaxPoints];
  int                 stored;
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_cycles;
  int                 errors;
  bit                 took;

  two_nearest_neighbour_triangles dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .px_i          (px_i),
    .py_i          (py_i),
    .pz_i          (pz_i),
    .last_point_i  (last_point_i),
    .empty         (empty),
    .pop           (pop),
    .center_index_o(center_index_o),
    .near_index_o  (near_index_o),
    .second_index_o(second_index_o),
    .last_face_o   (last_face_o),
    .too_few_o     (too_few_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned sq_dist(int a, int b);
    longint dx, dy, dz;
    dx = longint'(xs[a]) - longint'(xs[b]);
    dy = longint'(ys[a]) - longint'(ys[b]);
    dz = longint'(zs[a]) - longint'(zs[b]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // store the point; on the flagged one, queue the faces of the whole set
  task automatic load_point(point_t p);
    face_t f;
    int n, bi, si;
    longint unsigned d, bd, sd;
    bit have_b, have_s;
    if (stored < MaxPoints) begin
      xs[stored] = p.x;
      ys[stored] = p.y;
      zs[stored] = p.z;
      stored++;
    end
    if (!p.last) return;
    n = stored;
    stored = 0;
    if (n < 3) begin
      f = '{center: '0, near: '0, second: '0, last_face: 1'b1, too_few: 1'b1};
      face_q.insert(face_q.size(), f);
      return;
    end
    for (int i = 0; i < n; i++) begin
      bi = 0; si = 0; bd = '1; sd = '1; have_b = 0; have_s = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        d = sq_dist(i, j);
        if (!have_b || d < bd) begin
          if (have_b) begin
            sd = bd; si = bi; have_s = 1;
          end
          bd = d; bi = j; have_b = 1;
        end else if (!have_s || d < sd) begin
          sd = d; si = j; have_s = 1;
        end
      end
      f = '{center: i[IdxBits-1:0], near: bi[IdxBits-1:0], second: si[IdxBits-1:0],
            last_face: (i == n - 1), too_few: 1'b0};
      face_q.insert(face_q.size(), f);
    end
  endtask

  always @(posedge clk_i) begin
    face_t e;
    if (rst_ni) begin
      if (push && !full) begin
        load_point('{x: px_i, y: py_i, z: pz_i, last: last_point_i});
        took = 1'b1;
      end
      if (pop && !empty) begin
        if (face_q.size() == 0) begin
          $error("face transfer with no face expected");
          errors++;
        end else begin
          e = face_q.pop_front();
          if (center_index_o !== e.center) begin
            $error("center_index: expected %0d, got %0d", e.center, center_index_o);
            errors++;
          end
          if (near_index_o !== e.near) begin
            $error("near_index: expected %0d, got %0d", e.near, near_index_o);
            errors++;
          end
          if (second_index_o !== e.second) begin
            $error("second_index: expected %0d, got %0d", e.second, second_index_o);
            errors++;
          end
          if (last_face_o !== e.last_face) begin
            $error("last_face: expected %0b, got %0b", e.last_face, last_face_o);
            errors++;
          end
          if (too_few_o !== e.too_few) begin
            $error("too_few: expected %0b, got %0b", e.too_few, too_few_o);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    point_t p;
    if (rst_ni) begin
      if (!push || took) begin
        took = 1'b0;
        if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          p = point_q.pop_front();
          px_i         <= p.x;
          py_i         <= p.y;
          pz_i         <= p.z;
          last_point_i <= p.last;
          push         <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(3) == 0 ? 16'sh8000 : 16'sh7fff;
      1: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_set(int n);
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      point_q.insert(point_q.size(), '{x: rand_coord(mode), y: rand_coord(mode),
                                       z: rand_coord(mode), last: (i == n - 1)});
    end
  endtask

  task automatic add_point(int x, int y, int z, bit last);
    point_q.insert(point_q.size(), '{x: 16'(x), y: 16'(y), z: 16'(z), last: last});
  endtask

  task automatic drain();
    while (point_q.size() != 0 || push || face_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    px_i = '0;
    py_i = '0;
    pz_i = '0;
    last_point_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    errors = 0;
    stored = 0;
    took = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // single point, two points: error face
    add_point(0, 0, 0, 1);
    add_point(-32768, 32767, -32768, 0);
    add_point(32767, -32768, 32767, 1);
    // extremes, three points
    add_point(-32768, -32768, -32768, 0);
    add_point(32767, 32767, 32767, 0);
    add_point(-32768, 32767, 0, 1);
    // identical points: all ties go to lower index
    for (int i = 0; i < 5; i++) add_point(100, -100, 7, i == 4);
    // equidistant neighbours around a center
    add_point(0, 0, 0, 0);
    add_point(1, 0, 0, 0);
    add_point(-1, 0, 0, 0);
    add_point(0, 1, 0, 0);
    add_point(0, 0, -1, 1);
    // adjacent on a line
    for (int i = 0; i < 6; i++) add_point(i * 3, 0, 0, i == 5);
    drain();

    add_set(64);
    add_set(70);
    for (int i = 0; i < 6; i++) add_set($urandom_range(1, 10));
    drain();

    idle_pct = 55;
    for (int i = 0; i < 6; i++) add_set($urandom_range(2, 10));
    drain();

    idle_pct = 0;
    stall_pct = 55;
    for (int i = 0; i < 6; i++) add_set($urandom_range(2, 10));
    drain();

    idle_pct = 18;
    stall_pct = 18;
    for (int i = 0; i < 6; i++) add_set($urandom_range(1, 12));
    drain();

    // long receiver hold-off while the sender keeps offering
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 3000;
    add_set(16);
    for (int i = 0; i < 4; i++) add_set($urandom_range(3, 8));
    drain();

    if (errors == 0 && face_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tnnt_pkg.sv
hdl/tnnt_front.sv
hdl/tnnt_back.sv
hdl/two_nearest_neighbour_triangles.sv
hdl/tnnt_checker.sv
bench/two_nearest_neighbour_triangles_tb.sv
